/* hw/rtl/stereo_linear_resampler_core_defines.svh */
// assertion macros for the stereo linear resampler
`ifndef STEREO_LINEAR_RESAMPLER_CORE_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define SLR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define SLR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/slr_pkg.sv */
// shared types and constants of the stereo linear resampler
package slr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W = 23;
   localparam int MAX_OUT = 64;
   localparam int CNT_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] STEP_RESET = 23'd262144;

   // register index as seen on the word-aligned address
   localparam logic REG_PHASE_STEP = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SUM
   } state_type;

endpackage

/* hw/rtl/slr_lane.sv */
// one channel of the interpolator: multiply stage, then shift, add and saturate
module slr_lane #(
   parameter int FRACTION_BITS = 18
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]  prev_sample,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]  cur_sample,
   input  logic        [FRACTION_BITS-1:0]      frac,
   output logic signed [slr_pkg::SAMPLE_W-1:0]  sample_out
);

   localparam int DIFF_W = slr_pkg::SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
   localparam int SHIFT_W = PROD_W - FRACTION_BITS;
   localparam int SUM_W = SHIFT_W + 1;

   logic signed [DIFF_W-1:0]            diff;
   logic signed [FRACTION_BITS:0]       frac_ext;
   logic signed [PROD_W-1:0]            prod_in;
   logic signed [PROD_W-1:0]            prod_ff;
   logic signed [slr_pkg::SAMPLE_W-1:0] base_ff;
   logic        [SHIFT_W-1:0]           shifted;
   logic        [SUM_W-1:0]             sum;
   logic                                over_pos;
   logic                                over_neg;

   assign diff = $signed({cur_sample[slr_pkg::SAMPLE_W-1], cur_sample})
               - $signed({prev_sample[slr_pkg::SAMPLE_W-1], prev_sample});
   assign frac_ext = $signed({1'b0, frac});
   assign prod_in = diff * frac_ext;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         base_ff <= prev_sample;
      end
   end

   // floor shift is just dropping the fraction bits of a two's complement product
   assign shifted = prod_ff[PROD_W-1:FRACTION_BITS];
   assign sum = {shifted[SHIFT_W-1], shifted}
              + {{(SUM_W-slr_pkg::SAMPLE_W){base_ff[slr_pkg::SAMPLE_W-1]}}, base_ff};

   assign over_pos = !sum[SUM_W-1] && (sum[SUM_W-2:slr_pkg::SAMPLE_W-1] != '0);
   assign over_neg = sum[SUM_W-1] && (sum[SUM_W-2:slr_pkg::SAMPLE_W-1] != '1);

   always_comb begin
      if (over_pos) begin
         sample_out = {1'b0, {(slr_pkg::SAMPLE_W-1){1'b1}}};
      end else if (over_neg) begin
         sample_out = {1'b1, {(slr_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
         sample_out = sum[slr_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

/* hw/rtl/stereo_linear_resampler_core.sv */
// top level of the stereo linear resampler: control, phase, lanes and output register
//
//   channel   direction  handshake                   payload
//   req       in         req_valid / req_ready       req_left_in, req_right_in,
//                                                    req_first_of_block
//   rsp       out        rsp_valid / rsp_ready       rsp_left_out, rsp_right_out, rsp_last
//   csr       in/out     psel, penable, pwrite       paddr, pwdata, prdata (pready tied high)
//
// a frame that only loads (block start or no previous frame) leaves the sequencer in idle
// any other frame yields n results (1 to 64), or none, stepping through the states:
//   one phase check per result plus the lane multiply, then a sum/saturate state
// the sum state waits while the output register is still full and rsp_ready is low
// reset is synchronous; it clears the phase and the previous-frame flag, step back to unity
// a new frame is taken as soon as the last result sits in the output register
module stereo_linear_resampler_core #(
   parameter int FRACTION_BITS = 18
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]    req_left_in,
   input  logic signed [slr_pkg::SAMPLE_W-1:0]    req_right_in,
   input  logic                                   req_first_of_block,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [slr_pkg::SAMPLE_W-1:0]    rsp_left_out,
   output logic signed [slr_pkg::SAMPLE_W-1:0]    rsp_right_out,
   output logic                                   rsp_last,

   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic        [slr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic        [slr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic        [slr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready
);

   // phase holds up to one plus a full step
   localparam int PH_W = ((FRACTION_BITS > slr_pkg::STEP_W) ?
                          FRACTION_BITS : slr_pkg::STEP_W) + 1;
   localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRACTION_BITS;

   slr_pkg::state_type                  state_ff, state_in;

   logic [slr_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [PH_W-1:0]                     phase_ff, phase_in;
   logic                                have_prev_ff, have_prev_in;
   logic [slr_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic                                last_ff, last_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic signed [slr_pkg::SAMPLE_W-1:0] prev_left_ff, prev_left_in;
   logic signed [slr_pkg::SAMPLE_W-1:0] prev_right_ff, prev_right_in;
   logic signed [slr_pkg::SAMPLE_W-1:0] cur_left_ff;
   logic signed [slr_pkg::SAMPLE_W-1:0] cur_right_ff;
   logic signed [slr_pkg::SAMPLE_W-1:0] out_left_ff;
   logic signed [slr_pkg::SAMPLE_W-1:0] out_right_ff;
   logic                                out_last_ff;

   logic signed [slr_pkg::SAMPLE_W-1:0] lane_left;
   logic signed [slr_pkg::SAMPLE_W-1:0] lane_right;

   logic                                accept;
   logic                                load_only;
   logic                                phase_lt_one;
   logic [PH_W-1:0]                     next_phase;
   logic                                out_free;
   logic                                emit;
   logic                                out_load;
   logic                                finish;
   logic                                csr_write;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      step_in = step_ff;
      if (csr_write && (paddr[2] == slr_pkg::REG_PHASE_STEP)) begin
         step_in = pwdata[slr_pkg::STEP_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == slr_pkg::REG_PHASE_STEP) begin
         prdata = {{(slr_pkg::CSR_DATA_W-slr_pkg::STEP_W){1'b0}}, step_ff};
      end else begin
         prdata = '0;
      end
   end

   // ---------------------------------------------------------------------
   // datapath decisions
   // ---------------------------------------------------------------------
   assign accept = req_valid && req_ready;
   // block start, or nothing to interpolate from yet: just load the frame
   assign load_only = accept && (req_first_of_block || !have_prev_ff);
   assign phase_lt_one = (phase_ff < ONE);
   assign next_phase = phase_ff + PH_W'(step_ff);
   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slr_pkg::ST_IDLE: begin
            if (accept && !load_only) begin
               state_in = slr_pkg::ST_EVAL;
            end
         end
         slr_pkg::ST_EVAL: begin
            if (phase_lt_one) begin
               state_in = slr_pkg::ST_SUM;
            end else begin
               state_in = slr_pkg::ST_IDLE;
            end
         end
         slr_pkg::ST_SUM: begin
            if (out_free) begin
               state_in = last_ff ? slr_pkg::ST_IDLE : slr_pkg::ST_EVAL;
            end
         end
         default: begin
            state_in = slr_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      emit = 1'b0;
      out_load = 1'b0;
      finish = 1'b0;
      case (state_ff)
         slr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         slr_pkg::ST_EVAL: begin
            // phase below one: launch both lane multiplies, else the frame is done
            emit = phase_lt_one;
            finish = !phase_lt_one;
         end
         slr_pkg::ST_SUM: begin
            out_load = out_free;
            finish = out_free && last_ff;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // phase, count and frame bookkeeping
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      have_prev_in = have_prev_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      prev_left_in = prev_left_ff;
      prev_right_in = prev_right_ff;

      if (load_only) begin
         phase_in = '0;
         have_prev_in = 1'b1;
         prev_left_in = req_left_in;
         prev_right_in = req_right_in;
      end else if (accept) begin
         cnt_in = '0;
      end

      if (emit) begin
         phase_in = next_phase;
         cnt_in = cnt_ff + slr_pkg::CNT_W'(1);
         // final result when the phase reaches one or the per-frame cap is hit
         last_in = (next_phase >= ONE) || (cnt_ff == slr_pkg::CNT_W'(slr_pkg::MAX_OUT - 1));
      end

      if (finish) begin
         // subtract one; a capped frame that never reached one restarts at zero
         phase_in = (phase_ff >= ONE) ? (phase_ff - ONE) : '0;
         prev_left_in = cur_left_ff;
         prev_right_in = cur_right_ff;
      end
   end

   // output register: merge of both lanes plus the last marker
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slr_pkg::ST_IDLE;
         step_ff <= slr_pkg::STEP_RESET;
         phase_ff <= '0;
         have_prev_ff <= 1'b0;
         cnt_ff <= '0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         phase_ff <= phase_in;
         have_prev_ff <= have_prev_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample payload, only read once loaded
   always_ff @(posedge clock) begin
      prev_left_ff <= prev_left_in;
      prev_right_ff <= prev_right_in;
      if (accept) begin
         cur_left_ff <= req_left_in;
         cur_right_ff <= req_right_in;
      end
      if (out_load) begin
         out_left_ff <= lane_left;
         out_right_ff <= lane_right;
         out_last_ff <= last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // one interpolation lane per channel
   // ---------------------------------------------------------------------
   slr_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_left (
      .clock       (clock),
      .load        (emit),
      .prev_sample (prev_left_ff),
      .cur_sample  (cur_left_ff),
      .frac        (phase_ff[FRACTION_BITS-1:0]),
      .sample_out  (lane_left)
   );

   slr_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_right (
      .clock       (clock),
      .load        (emit),
      .prev_sample (prev_right_ff),
      .cur_sample  (cur_right_ff),
      .frac        (phase_ff[FRACTION_BITS-1:0]),
      .sample_out  (lane_right)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = out_left_ff;
   assign rsp_right_out = out_right_ff;
   assign rsp_last = out_last_ff;

endmodule

/* hw/rtl/slr_checker.sv */
// port-level checks of the stereo linear resampler, bound to the top level
`include "stereo_linear_resampler_core_defines.svh"

module slr_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   req_first_of_block,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [slr_pkg::SAMPLE_W-1:0]    rsp_left_out,
   input logic signed [slr_pkg::SAMPLE_W-1:0]    rsp_right_out,
   input logic                                   rsp_last,
   input logic                                   psel,
   input logic                                   penable,
   input logic                                   pwrite,
   input logic        [slr_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic        [slr_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic        [slr_pkg::CSR_DATA_W-1:0]  prdata,
   input logic                                   pready
);

   // a stalled result transaction keeps its payload
   `SLR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out) && $stable(rsp_last), "rsp payload changed while stalled")

   // a block-start frame only loads, so the block is ready again at once
   `SLR_ASSERT_NXT(a_start_ready, req_valid && req_ready && req_first_of_block, req_ready, "not ready after block start")

   // the step register reads back what was written
   `SLR_ASSERT_NXT(a_step_rb, psel && penable && pwrite && pready && (paddr[2] == slr_pkg::REG_PHASE_STEP), (paddr[2] != slr_pkg::REG_PHASE_STEP) || (prdata[slr_pkg::STEP_W-1:0] == $past(pwdata[slr_pkg::STEP_W-1:0])), "phase_step read-back mismatch")

   // unused high bits of the step register read as zero
   `SLR_ASSERT_IMP(a_step_hi, 1'b1, prdata[slr_pkg::CSR_DATA_W-1:slr_pkg::STEP_W] == '0, "prdata upper bits not zero")

endmodule

bind stereo_linear_resampler_core slr_checker u_slr_checker (.*);
